// ----- rtl/iwq_pkg.sv -----
package iwq_pkg;

  typedef enum logic [1:0] {
    FUNC_SCAN  = 2'd0,
    FUNC_CLOSE = 2'd1,
    FUNC_QUANT = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BIG  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  localparam logic [1:0] REG_WRATIO = 2'd0;
  localparam logic [1:0] REG_BRATIO = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_BRANGE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] weight;
    logic signed [31:0] bias;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [4:0]         shift;
    logic [31:0]        multiplier;
    logic               saturated;
    logic [1:0]         status;
  } out_beat_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        close;
    logic        neg;
    logic [31:0] mag;
  } cmd_t;

  typedef struct packed {
    logic [23:0] weight_ratio;
    logic [31:0] bias_ratio;
    logic        quant_mode;
    logic        bias_range;
  } cfg_t;

endpackage

// ----- rtl/iwq_front.sv -----
module iwq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  iwq_pkg::in_beat_t in_data,
  output logic             q_valid,
  input  logic             q_ready,
  output iwq_pkg::cmd_t    q_cmd
);

  logic          full_r, full_nxt;
  iwq_pkg::cmd_t cmd_r;
  logic          take;
  logic          neg;
  logic [16:0]   wmag;

  assign in_ready = !full_r || q_ready;
  assign take     = in_valid && in_ready;
  assign q_valid  = full_r;
  assign q_cmd    = cmd_r;

  always_comb begin
    neg  = in_data.weight[15];
    wmag = neg ? (17'd0 - {1'b1, in_data.weight}) : {1'b0, in_data.weight};
    full_nxt = full_r;
    if (q_ready) full_nxt = 1'b0;
    if (take && (in_data.func == iwq_pkg::FUNC_CLOSE || in_data.func == iwq_pkg::FUNC_QUANT))
      full_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (in_data.func == iwq_pkg::FUNC_CLOSE) begin
        cmd_r.close <= 1'b1;
        cmd_r.neg   <= in_data.bias[31];
        cmd_r.mag   <= in_data.bias[31] ? 32'd0 - in_data.bias : in_data.bias;
      end else begin
        cmd_r.close <= 1'b0;
        cmd_r.neg   <= neg;
        cmd_r.mag   <= {15'd0, wmag};
      end
    end
  end

endmodule

// ----- rtl/iwq_fifo.sv -----
module iwq_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  iwq_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output iwq_pkg::cmd_t rd_cmd
);

  iwq_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_cmd   = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_cmd;
  end

endmodule

// ----- rtl/iwq_back.sv -----
module iwq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  iwq_pkg::cfg_t     cfg,
  input  logic              scan_en,
  input  logic [15:0]       scan_mag,
  input  logic              c_valid,
  output logic              c_ready,
  input  iwq_pkg::cmd_t     c_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output iwq_pkg::out_beat_t out_data,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_DIV, S_BMUL, S_BMUL2, S_FIN
  } state_t;

  state_t      state_r;
  logic [15:0] max_r;
  logic [4:0]  shift_r;
  logic [31:0] factor_r;
  logic        close_r, neg_r;
  logic [31:0] mag_r;
  logic [39:0] a_r;
  logic [63:0] p_r;
  logic [45:0] rem_r;
  logic [51:0] quo_r;
  logic [5:0]  cnt_r;
  logic [72:0] prod_r;
  logic [1:0]  stat_r;
  iwq_pkg::out_beat_t od_r;
  logic        ov_r;
  logic [4:0]  sh_nxt;
  logic [46:0] trial;
  logic [63:0] q;
  logic        sat;
  logic [31:0] v;

  assign c_ready   = state_r == S_IDLE && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign busy      = state_r != S_IDLE || c_valid;
  assign trial     = {rem_r, quo_r[51]} - {7'd0, a_r};

  always_comb begin
    sh_nxt = 5'd31;
    for (int k = 31; k >= 0; k--) begin
      if (a_r >= (40'd1 << (34 - k))) sh_nxt = 5'(k);
    end
  end

  // final magnitude, from the product of the last multiply
  always_comb begin
    if (close_r) begin
      if (cfg.quant_mode) q = {16'd0, prod_r[63:16]};
      else q = prod_r[63:0];
    end else begin
      if (cfg.quant_mode) q = {35'd0, prod_r[72:44]};
      else q = {19'd0, prod_r[72:28]};
    end
    sat = 1'b0;
    if (!close_r) begin
      if (!neg_r) begin sat = q > 64'd127; v = sat ? 32'd127 : q[31:0]; end
      else begin sat = q > 64'd128; v = sat ? -32'd128 : 32'd0 - q[31:0]; end
    end else if (cfg.bias_range) begin
      if (!neg_r) begin sat = q > 64'h7FFFFFFF; v = sat ? 32'h7FFFFFFF : q[31:0]; end
      else begin sat = q > 64'h80000000; v = sat ? 32'h80000000 : 32'd0 - q[31:0]; end
    end else begin
      if (!neg_r) begin sat = q > 64'd65535; v = sat ? 32'd65535 : q[31:0]; end
      else begin sat = q > 64'd65536; v = sat ? -32'd65536 : 32'd0 - q[31:0]; end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      max_r    <= 16'd0;
      shift_r  <= 5'd0;
      factor_r <= 32'd0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (scan_en && scan_mag > max_r) max_r <= scan_mag;
      unique case (state_r)
        S_IDLE: begin
          if (c_valid && !ov_r) begin
            close_r <= c_cmd.close;
            neg_r   <= c_cmd.neg;
            mag_r   <= c_cmd.mag;
            a_r     <= 40'(max_r) * 40'(cfg.weight_ratio);
            if (!c_cmd.close) p_r <= 64'(c_cmd.mag[16:0]) * 64'(cfg.weight_ratio);
            state_r <= c_cmd.close ? S_MUL1 : S_BMUL;
          end
        end
        S_MUL1: begin
          p_r     <= 64'(mag_r) * 64'(cfg.bias_ratio);
          max_r   <= 16'd0;
          stat_r  <= (a_r == 40'd0) ? iwq_pkg::ST_ZERO :
                     (a_r >= (40'd1 << 35)) ? iwq_pkg::ST_BIG : iwq_pkg::ST_OK;
          if (cfg.quant_mode) begin
            shift_r <= 5'd0;
            rem_r   <= 46'd0;
            quo_r   <= (52'd127 << 44) + 52'(a_r >> 1);
            cnt_r   <= 6'd52;
            state_r <= (a_r == 40'd0) ? S_BMUL : S_DIV;
            if (a_r == 40'd0) factor_r <= 32'hFFFFFFFF;
          end else begin
            shift_r  <= sh_nxt;
            factor_r <= 32'd0;
            state_r  <= S_BMUL;
          end
        end
        S_DIV: begin
          if (trial[46]) begin
            rem_r <= {rem_r[44:0], quo_r[51]};
            quo_r <= {quo_r[50:0], 1'b0};
          end else begin
            rem_r <= trial[45:0];
            quo_r <= {quo_r[50:0], 1'b1};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= S_BMUL2;
        end
        S_BMUL2: begin
          factor_r <= (quo_r[51:32] != 20'd0) ? 32'hFFFFFFFF : quo_r[31:0];
          state_r  <= S_BMUL;
        end
        S_BMUL: begin
          // weight: p=m*ratio; bias: p=|b|*bias_ratio
          if (cfg.quant_mode) begin
            if (close_r) prod_r <= 73'(p_r[63:32]) * 73'(factor_r)
                                  + ((73'(p_r[31:0]) * 73'(factor_r)) >> 32);
            else prod_r <= ((73'(p_r[40:0]) * 73'(factor_r[31:16])) << 16)
                           + (73'(p_r[40:0]) * 73'(factor_r[15:0]))
                           + (73'd1 << 43);
          end else begin
            if (close_r) prod_r <= 73'(p_r >> (6'd32 - {1'b0, shift_r}));
            else prod_r <= (73'(p_r[40:0]) << shift_r) + (73'd1 << 27);
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          od_r.value      <= v;
          od_r.shift      <= shift_r;
          od_r.multiplier <= factor_r;
          od_r.saturated  <= sat;
          od_r.status     <= close_r ? stat_r : iwq_pkg::ST_OK;
          ov_r            <= 1'b1;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/int8_weight_quantizer.sv -----
// steps: scan updates the max at its accepting edge, no result; quantize runs S_BMUL,
// S_FIN to out_valid; close runs S_MUL1, S_BMUL, S_FIN, and in multiplier mode with a
// nonzero max S_MUL1, S_DIV (52-step restoring division of the reciprocal), S_BMUL2,
// S_BMUL, S_FIN; the single back-end sequencer takes one quantize or close at a time,
// none while its result waits for out_ready; scans one per cycle, held while any
// quantize or close is in flight
// reset: synchronous active-low rst_n clears max, shift, factor, queue and
// registers return weight_ratio 65536, bias_ratio 65536, modes 0
module int8_weight_quantizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iwq_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iwq_pkg::out_beat_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  iwq_pkg::cfg_t cfg_r;
  iwq_pkg::cmd_t f_cmd, b_cmd;
  logic          f_valid, f_ready, b_valid, b_ready, busy;
  logic          front_ready, scan_en, scan_block;
  logic [15:0]   scan_mag;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      iwq_pkg::REG_WRATIO: prdata = {8'd0, cfg_r.weight_ratio};
      iwq_pkg::REG_BRATIO: prdata = cfg_r.bias_ratio;
      iwq_pkg::REG_MODE:   prdata = {31'd0, cfg_r.quant_mode};
      default:             prdata = {31'd0, cfg_r.bias_range};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{weight_ratio: 24'd65536, bias_ratio: 32'd65536,
                 quant_mode: 1'b0, bias_range: 1'b0};
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        iwq_pkg::REG_WRATIO: cfg_r.weight_ratio <= pwdata[23:0];
        iwq_pkg::REG_BRATIO: cfg_r.bias_ratio   <= pwdata;
        iwq_pkg::REG_MODE:   cfg_r.quant_mode   <= pwdata[0];
        default:             cfg_r.bias_range   <= pwdata[0];
      endcase
    end
  end

  // scans wait until earlier closes have cleared the max
  assign scan_block = busy || f_valid;
  assign in_ready = front_ready && !(in_data.func == iwq_pkg::FUNC_SCAN && scan_block);
  assign scan_en  = in_valid && in_ready && in_data.func == iwq_pkg::FUNC_SCAN;
  assign scan_mag = in_data.weight[15] ? 16'd0 - in_data.weight : in_data.weight;

  iwq_front u_front (
    .clk, .rst_n,
    .in_valid (in_valid && !(in_data.func == iwq_pkg::FUNC_SCAN && scan_block)),
    .in_ready (front_ready),
    .in_data,
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_cmd    (f_cmd)
  );

  iwq_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid (f_valid), .wr_ready (f_ready), .wr_cmd (f_cmd),
    .rd_valid (b_valid), .rd_ready (b_ready), .rd_cmd (b_cmd)
  );

  iwq_back u_back (
    .clk, .rst_n,
    .cfg      (cfg_r),
    .scan_en,
    .scan_mag,
    .c_valid  (b_valid),
    .c_ready  (b_ready),
    .c_cmd    (b_cmd),
    .out_valid, .out_ready, .out_data,
    .busy
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_qnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != iwq_pkg::ST_OK |-> out_data.status != 2'd3)
    else $error("bad status");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated && out_data.value[31] |-> out_data.value != 32'd0)
    else $error("saturated negative value is zero");

endmodule
